@@ rtl/core/pna_pkg.sv @@
`default_nettype none
package pna_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned SCAN_W = 16;
  localparam int unsigned PCT_W = 14;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned BIT_IDX_W = 5;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);
  localparam logic [DIVISOR_W-1:0] PCT_SCALE = DIVISOR_W'(10000);

  localparam logic REG_PERCENTILE = 1'b0;
  localparam logic REG_SCANS = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/pna_divider.sv @@
`default_nettype none
module pna_divider import pna_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [SUM_W-1:0]     dividend_i,
  input  wire logic [DIVISOR_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [SUM_W-1:0]          quotient_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] div_q;
  logic [STEP_W-1:0]    step_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  assign shifted = {rem_q, quo_q[SUM_W-1]};
  assign fits = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? DIVISOR_W'(shifted - {1'b0, div_q}) : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

@@ rtl/core/percentile_noise_average.sv @@
// Peaks load at one transaction per cycle while a scan is collected.
// At a scan end the rank is computed from the peak count and the percentile,
// the bitwise selection takes 32 passes over the store of n stored peaks, and
// the average follows once the scan count completes, and the result is registered.
// Reset clears all control state and sets the registers to their defaults;
// the peak store needs no clearing.
`default_nettype none
module percentile_noise_average import pna_pkg::*; #(
  parameter int unsigned MAX_PEAKS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DATA_W-1:0] intensity_i,
  input  wire logic              last_in_scan_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [DATA_W-1:0] scan_level_o,
  output logic      [DATA_W-1:0] average_level_o,
  output logic                   final_res_o,
  output logic                   overflow_o
);

  localparam int unsigned AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int unsigned CW = $clog2(MAX_PEAKS + 1);
  localparam int unsigned PROD_W = CW + PCT_W;
  localparam int unsigned RANK_SHIFT = PROD_W + PCT_W;
  localparam int unsigned RECIP_W = PROD_W + 1;
  localparam int unsigned SCALED_W = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RANK_RECIP =
    RECIP_W'(((64'd1 << RANK_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));

  typedef enum logic [2:0] {S_LOAD, S_RANK, S_SEL, S_AVG, S_OUT} state_e;

  state_e              state_q;
  logic [PCT_W-1:0]    pct_q;
  logic [SCAN_W-1:0]   scans_cfg_q;
  logic [CW-1:0]       count_q;
  logic                dropped_q;
  logic [SCAN_W-1:0]   scans_done_q;
  logic [SUM_W-1:0]    sum_q;
  logic [CW-1:0]       rank_q;
  logic [DATA_W-1:0]   prefix_q;
  logic [DATA_W-1:0]   mask_q;
  logic [BIT_IDX_W-1:0] bit_q;
  logic [CW-1:0]       idx_q;
  logic [CW-1:0]       hits_q;
  logic                rd_vld_q;
  logic                rd_last_q;
  logic [DATA_W-1:0]   rd_data_q;
  logic                fin_q;
  logic                div_start_q;
  logic [SUM_W-1:0]    div_a_q;
  logic [DIVISOR_W-1:0] div_b_q;
  logic                out_valid_q;
  logic [DATA_W-1:0]   level_q;
  logic [DATA_W-1:0]   avg_q;
  logic [DATA_W-1:0]   scan_level_q;
  logic [DATA_W-1:0]   average_level_q;
  logic                final_res_q;
  logic                overflow_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SCALED_W-1:0] scaled_q;
  logic                rank_step_q;

  logic [DATA_W-1:0]   mem [MAX_PEAKS];

  logic                accept;
  logic                store_en;
  logic                read_en;
  logic [CW-1:0]       count_new;
  logic [PCT_W-1:0]    pct_clamped;
  logic [SCAN_W-1:0]   target;
  logic                hit;
  logic [CW-1:0]       hits_sum;
  logic                take_one;
  logic [DATA_W-1:0]   prefix_nx;
  logic [SUM_W-1:0]    sum_new;
  logic [SCAN_W-1:0]   scans_new;
  logic                fin_new;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                wr_cfg;
  logic [CW:0]         rank_quo;
  logic                avg_go;

  pna_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign accept = in_valid_i && in_ready_o;
  assign store_en = accept && (count_q < CW'(MAX_PEAKS));
  assign count_new = store_en ? count_q + 1'b1 : count_q;
  assign read_en = (state_q == S_SEL) && (idx_q < count_q);
  assign pct_clamped = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
  assign target = (scans_cfg_q == '0) ? SCAN_W'(1) : scans_cfg_q;
  assign rank_quo = scaled_q[RANK_SHIFT +: CW + 1];

  assign hit = (((rd_data_q ^ prefix_q) & mask_q) == '0) && !rd_data_q[bit_q];
  assign hits_sum = hits_q + CW'(hit);
  assign take_one = !(rank_q < hits_sum);
  assign prefix_nx = prefix_q | (take_one ? (DATA_W'(1) << bit_q) : '0);
  assign sum_new = sum_q + {{(SUM_W-DATA_W){1'b0}}, prefix_nx};
  assign scans_new = scans_done_q + 1'b1;
  assign fin_new = (scans_new >= target) || (scans_new == '0);
  assign avg_go = (state_q == S_SEL) && rd_last_q && (bit_q == '0) && fin_new;

  assign wr_cfg = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SCANS) ? {16'b0, scans_cfg_q} : {18'b0, pct_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= PCT_W'(5000);
      scans_cfg_q <= SCAN_W'(1);
    end else if (wr_cfg) begin
      if (paddr[2] == REG_PERCENTILE) begin
        pct_q <= pwdata[PCT_W-1:0];
      end else begin
        scans_cfg_q <= pwdata[SCAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[count_q[AW-1:0]] <= intensity_i;
    end
    if (read_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      dropped_q <= 1'b0;
      scans_done_q <= '0;
      sum_q <= '0;
      rd_vld_q <= 1'b0;
      rd_last_q <= 1'b0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      hits_q <= '0;
      rank_step_q <= 1'b0;
    end else begin
      div_start_q <= avg_go;
      rd_vld_q <= read_en;
      rd_last_q <= read_en && (idx_q == count_q - 1'b1);
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            count_q <= count_new;
            if (!store_en) begin
              dropped_q <= 1'b1;
            end
            if (last_in_scan_i) begin
              prod_q <= PROD_W'(count_new) * PROD_W'(pct_clamped);
              state_q <= S_RANK;
            end
          end
        end
        S_RANK: begin
          if (!rank_step_q) begin
            scaled_q <= SCALED_W'(prod_q) * SCALED_W'(RANK_RECIP);
            rank_step_q <= 1'b1;
          end else begin
            rank_q <= (rank_quo > {1'b0, count_q - 1'b1}) ? count_q - 1'b1 : rank_quo[CW-1:0];
            rank_step_q <= 1'b0;
            prefix_q <= '0;
            mask_q <= '0;
            bit_q <= BIT_IDX_W'(DATA_W - 1);
            idx_q <= '0;
            hits_q <= '0;
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          if (read_en) begin
            idx_q <= idx_q + 1'b1;
          end
          if (rd_vld_q && !rd_last_q) begin
            hits_q <= hits_sum;
          end
          if (rd_last_q) begin
            if (take_one) begin
              rank_q <= rank_q - hits_sum;
            end
            prefix_q <= prefix_nx;
            mask_q[bit_q] <= 1'b1;
            hits_q <= '0;
            idx_q <= '0;
            if (bit_q == '0) begin
              level_q <= prefix_nx;
              sum_q <= sum_new;
              scans_done_q <= scans_new;
              fin_q <= fin_new;
              avg_q <= '0;
              if (fin_new) begin
                div_a_q <= sum_new;
                div_b_q <= target;
                state_q <= S_AVG;
              end else begin
                state_q <= S_OUT;
              end
            end else begin
              bit_q <= bit_q - 1'b1;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg_q <= (div_quo > SUM_W'(32'hFFFF_FFFF)) ? '1 : div_quo[DATA_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            scan_level_q <= level_q;
            average_level_q <= avg_q;
            final_res_q <= fin_q;
            overflow_q <= dropped_q;
            count_q <= '0;
            dropped_q <= 1'b0;
            if (fin_q) begin
              sum_q <= '0;
              scans_done_q <= '0;
            end
            state_q <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign scan_level_o = scan_level_q;
  assign average_level_o = average_level_q;
  assign final_res_o = final_res_q;
  assign overflow_o = overflow_q;

endmodule
`default_nettype wire

@@ rtl/core/pna_checker.sv @@
`default_nettype none
module pna_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        last_in_scan_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] scan_level_o,
  input wire logic [31:0] average_level_o,
  input wire logic        final_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scan_level_o))
    else $error("Result transaction dropped or changed while stalled.");

  a_avg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_res_o |-> average_level_o == '0)
    else $error("Average is nonzero on a result that is not final.");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_in_scan_i |=> !in_ready_o)
    else $error("Input taken right after the last transaction of a scan.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_ready_o |=> !out_valid_o)
    else $error("Result appeared while no scan was being processed.");

endmodule

bind percentile_noise_average pna_checker u_pna_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .last_in_scan_i (last_in_scan_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .scan_level_o   (scan_level_o),
  .average_level_o(average_level_o),
  .final_res_o    (final_res_o)
);
`default_nettype wire

@@ verif/percentile_noise_average_tb.sv @@
`default_nettype none
module percentile_noise_average_tb import pna_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PEAKS = 1024;

  typedef struct {
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] average;
    logic              final_res;
    logic              overflow;
  } scan_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [DATA_W-1:0] intensity_i;
  logic              last_in_scan_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [DATA_W-1:0] scan_level_o;
  logic [DATA_W-1:0] average_level_o;
  logic              final_res_o;
  logic              overflow_o;

  percentile_noise_average #(.MAX_PEAKS(MAX_PEAKS)) dut (.*);

  // Predictor state.
  logic [DATA_W-1:0] scan_peaks[$];
  logic              peaks_dropped;
  logic [SCAN_W-1:0] scans_seen;
  logic [SUM_W-1:0]  level_total;
  logic [PCT_W-1:0]  pct_reg;
  logic [SCAN_W-1:0] scans_reg;
  scan_result_t      pending_scans[$];

  int unsigned error_count = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic        hold_active;
  event        hold_go;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic predict_peak(input logic [DATA_W-1:0] value, input logic last);
    logic [DATA_W-1:0] sorted[$];
    logic [63:0]       pct;
    logic [63:0]       rank;
    logic [63:0]       target;
    logic [63:0]       avg;
    scan_result_t      res;
    if (scan_peaks.size() < MAX_PEAKS) begin
      scan_peaks = {scan_peaks, value};
    end else begin
      peaks_dropped = 1'b1;
    end
    if (!last) return;
    pct = (pct_reg > PCT_FULL) ? 64'(PCT_FULL) : 64'(pct_reg);
    rank = (64'(scan_peaks.size()) * pct) / 64'(PCT_SCALE);
    if (rank > 64'(scan_peaks.size() - 1)) rank = 64'(scan_peaks.size() - 1);
    sorted = scan_peaks;
    sorted.sort();
    res.level = sorted[rank];
    level_total = level_total + SUM_W'(res.level);
    scans_seen = scans_seen + 1'b1;
    target = (scans_reg == '0) ? 64'd1 : 64'(scans_reg);
    res.final_res = (64'(scans_seen) >= target) || (scans_seen == '0);
    res.average = '0;
    if (res.final_res) begin
      avg = 64'(level_total) / target;
      res.average = (avg > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : avg[31:0];
      level_total = '0;
      scans_seen = '0;
    end
    res.overflow = peaks_dropped;
    pending_scans = {pending_scans, res};
    scan_peaks.delete();
    peaks_dropped = 1'b0;
  endtask

  // Called at a falling edge; leaves valid high after the transaction.
  task automatic send_peak(input logic [DATA_W-1:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    intensity_i <= value;
    last_in_scan_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_peak(value, last);
    @(negedge clk_i);
  endtask

  task automatic send_scan(input int unsigned len, input int unsigned mode);
    logic [DATA_W-1:0] value;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: value = $urandom;
        1: value = $urandom_range(7);
        2: value = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
        default: value = $urandom_range(255) << $urandom_range(24);
      endcase
      send_peak(value, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_scans.size() != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_PERCENTILE) pct_reg = value[PCT_W-1:0];
    else scans_reg = value[SCAN_W-1:0];
  endtask

  // The long receiver hold-off is timed here.
  initial begin
    hold_active = 1'b0;
    @(hold_go);
    hold_active = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold_active = 1'b0;
  end

  // Receiver side: random stalls plus an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_active) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    scan_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_scans.size() == 0) begin
        $display("%0t: unexpected transaction level %h", $realtime, scan_level_o);
        error_count++;
      end else begin
        exp_res = pending_scans.pop_front();
        if (scan_level_o !== exp_res.level) begin
          $display("%0t: scan_level expected %h actual %h",
                   $realtime, exp_res.level, scan_level_o);
          error_count++;
        end
        if (average_level_o !== exp_res.average) begin
          $display("%0t: average_level expected %h actual %h",
                   $realtime, exp_res.average, average_level_o);
          error_count++;
        end
        if (final_res_o !== exp_res.final_res) begin
          $display("%0t: final_res expected %b actual %b",
                   $realtime, exp_res.final_res, final_res_o);
          error_count++;
        end
        if (overflow_o !== exp_res.overflow) begin
          $display("%0t: overflow expected %b actual %b",
                   $realtime, exp_res.overflow, overflow_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_directed();
    send_peak(32'h0, 1'b1);
    send_peak(32'hFFFF_FFFF, 1'b1);
    send_peak(32'h5, 1'b0);
    send_peak(32'h5, 1'b0);
    send_peak(32'h1, 1'b0);
    send_peak(32'h5, 1'b1);
    wait_idle();
    write_reg(REG_PERCENTILE, 32'd0);
    send_peak(32'h30, 1'b0);
    send_peak(32'h10, 1'b0);
    send_peak(32'h20, 1'b1);
    wait_idle();
    write_reg(REG_PERCENTILE, 32'd10000);
    send_peak(32'h30, 1'b0);
    send_peak(32'hFFFF_FFFF, 1'b0);
    send_peak(32'h20, 1'b1);
    wait_idle();
    write_reg(REG_PERCENTILE, 32'h3FFF);
    write_reg(REG_SCANS, 32'd0);
    send_peak(32'h7, 1'b0);
    send_peak(32'h9, 1'b1);
    wait_idle();
    write_reg(REG_PERCENTILE, 32'd2500);
    write_reg(REG_SCANS, 32'd3);
    send_peak(32'h100, 1'b0);
    send_peak(32'h200, 1'b1);
    send_peak(32'h303, 1'b1);
    send_peak(32'h1, 1'b0);
    send_peak(32'h2, 1'b0);
    send_peak(32'h3, 1'b0);
    send_peak(32'h4, 1'b1);
    wait_idle();
  endtask

  task automatic test_store_full();
    write_reg(REG_PERCENTILE, 32'd9000);
    write_reg(REG_SCANS, 32'd1);
    send_scan(MAX_PEAKS + 3, 0);
    wait_idle();
  endtask

  task automatic test_average_saturation();
    write_reg(REG_PERCENTILE, 32'd5000);
    write_reg(REG_SCANS, 32'd65535);
    repeat (3) send_peak(32'hFFFF_FFFF, 1'b1);
    wait_idle();
    write_reg(REG_SCANS, 32'd1);
    send_peak(32'hFFFF_FFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_phase(input int unsigned idle, input int unsigned stall,
                                   input logic [31:0] pct, input logic [31:0] scans);
    int unsigned sent;
    int unsigned len;
    write_reg(REG_PERCENTILE, pct);
    write_reg(REG_SCANS, scans);
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < 170) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(16, 1);
      send_scan(len, $urandom_range(3));
      sent += len;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    write_reg(REG_PERCENTILE, 32'd7500);
    write_reg(REG_SCANS, 32'd2);
    -> hold_go;
    repeat (40) send_scan($urandom_range(3, 1), 0);
    wait_idle();
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    peaks_dropped = 1'b0;
    scans_seen = '0;
    level_total = '0;
    pct_reg = PCT_W'(5000);
    scans_reg = SCAN_W'(1);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    intensity_i = '0;
    last_in_scan_i = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_store_full();
    test_average_saturation();
    test_random_phase(0, 0, $urandom_range(10000), 1);
    test_random_phase(64, 0, $urandom_range(16383), 65535);
    test_random_phase(0, 64, 0, $urandom_range(8, 1));
    test_random_phase(7, 7, 10000, $urandom_range(4, 1));
    test_backpressure();

    if (error_count == 0 && pending_scans.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
